// File: rtl/core/crcfr_pkg.sv
// Shared types, constants and the CRC-32 byte update for the frame receiver.
package crcfr_pkg;

  // Frame framing bytes and limits.
  localparam logic [7:0]  HDR0          = 8'hAA;
  localparam logic [7:0]  HDR1          = 8'h55;
  localparam logic [7:0]  TAIL0         = 8'hFE;
  localparam logic [7:0]  TAIL1         = 8'hEF;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd18;
  localparam logic [15:0] MAX_FRAME_LEN = 16'd2048;

  // Offsets from the total length that mark the end of the argument bytes and the end of the
  // received CRC, which is also the first tail byte; then the count of header field bytes.
  localparam logic [15:0] CRC_END_OFS   = 16'd10;
  localparam logic [15:0] RCRC_END_OFS  = 16'd6;
  localparam logic [15:0] HDR_BYTES     = 16'd8;

  // Reflected CRC-32 constants.
  localparam logic [31:0] CRC_POLY_REFL = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES  = 32'hFFFFFFFF;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned ARGLEN_W = 11;

  typedef enum logic [2:0] {
    ST_HUNT0 = 3'd0,
    ST_HUNT1 = 3'd1,
    ST_LENH  = 3'd2,
    ST_LENL  = 3'd3,
    ST_BODY  = 3'd4
  } sync_state_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } result_kind_t;

  typedef enum logic [1:0] {
    STAT_GOOD     = 2'd0,
    STAT_TAIL_ERR = 2'd1,
    STAT_CRC_ERR  = 2'd2
  } frame_status_t;

  // One result beat as it travels from the parser to the output queue.
  typedef struct packed {
    result_kind_t          kind;
    logic [7:0]            payload_byte;
    frame_status_t         status;
    logic [7:0]            version;
    logic [15:0]           frame_type;
    logic [15:0]           sequence_res;
    logic [7:0]            channel;
    logic [15:0]           command;
    logic [ARGLEN_W-1:0]   arg_length;
  } result_t;

  // One byte through the reflected CRC-32, LSB first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] x;
    x = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY_REFL) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// File: rtl/core/crc32_frame_receiver.sv
// Top level of the byte-serial frame receiver with CRC-32 check.
// Takes one received byte per cycle, back to back, while in_stall is low, and gives at
// most one result beat per byte: each argument byte as a payload beat, and one frame-end
// beat with the verdict and header fields on the last tail byte. A result is registered in
// the output queue before it appears on the out_ port; the combinational CRC-32 byte update
// in the parser sets the critical path. A two-entry output queue lets input continue
// while a result waits; in_stall rises only when both entries are held by a stalled output.
// Lengths outside 18 to MAX_LEN bytes (2048 by default), and a bad second header byte, drop
// back to the header hunt silently.
module crc32_frame_receiver #(
  parameter logic [15:0] MAX_LEN = crcfr_pkg::MAX_FRAME_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_frame_status,
  output logic [7:0]  out_version,
  output logic [15:0] out_frame_type,
  output logic [15:0] out_sequence_res,
  output logic [7:0]  out_channel,
  output logic [15:0] out_command,
  output logic [10:0] out_arg_length
);
  import crcfr_pkg::*;

  logic    beat_acc;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    q_full;

  assign in_stall = q_full;
  assign beat_acc = in_valid && !q_full;

  crcfr_parser #(
    .MAX_LEN (MAX_LEN)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_acc  (beat_acc),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  crcfr_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res),
    .full       (q_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Unpack the result beat onto the output ports.
  assign out_result_kind  = out_data.kind;
  assign out_payload_byte = out_data.payload_byte;
  assign out_frame_status = out_data.status;
  assign out_version      = out_data.version;
  assign out_frame_type   = out_data.frame_type;
  assign out_sequence_res = out_data.sequence_res;
  assign out_channel      = out_data.channel;
  assign out_command      = out_data.command;
  assign out_arg_length   = out_data.arg_length;

endmodule

// File: rtl/core/crcfr_parser.sv
// Frame sync state machine, field capture and running CRC-32 check.
module crcfr_parser #(
  parameter logic [15:0] MAX_LEN = crcfr_pkg::MAX_FRAME_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat_acc,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output crcfr_pkg::result_t res
);
  import crcfr_pkg::*;

  sync_state_t   state_r, state_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic [31:0]   rcrc_r, rcrc_nxt;
  logic [7:0]    tail0_r, tail0_nxt;
  logic [63:0]   hdr_r, hdr_nxt;

  logic [31:0]   crc_upd;
  logic [15:0]   len_full;
  logic [15:0]   arg_len16;
  logic          in_crc, in_hdr, in_rcrc, at_tail0;
  frame_status_t status;

  // CRC of the current byte; a first header byte restarts from all ones.
  assign crc_upd   = crc32_byte((state_r == ST_HUNT0) ? CRC_ALL_ONES : crc_r, rx_byte);
  assign len_full  = {len_r[15:8], rx_byte};
  assign arg_len16 = len_r - MIN_FRAME_LEN;

  // Where the current body byte falls inside the frame.
  assign in_hdr   = pos_r < HDR_BYTES;
  assign in_crc   = pos_r < (len_r - CRC_END_OFS);
  assign in_rcrc  = pos_r < (len_r - RCRC_END_OFS);
  assign at_tail0 = pos_r == (len_r - RCRC_END_OFS);

  // Verdict at the last byte; a bad tail outranks a bad CRC.
  always_comb begin
    if (tail0_r != TAIL0 || rx_byte != TAIL1) begin
      status = STAT_TAIL_ERR;
    end else if ((crc_r ^ CRC_ALL_ONES) != rcrc_r) begin
      status = STAT_CRC_ERR;
    end else begin
      status = STAT_GOOD;
    end
  end

  // Next state and result for one accepted beat.
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    rcrc_nxt  = rcrc_r;
    tail0_nxt = tail0_r;
    hdr_nxt   = hdr_r;
    res_valid = 1'b0;
    res       = '0;

    if (beat_acc) begin
      unique case (state_r)
        ST_HUNT0: begin
          if (rx_byte == HDR0) begin
            crc_nxt   = crc_upd;
            state_nxt = ST_HUNT1;
          end
        end
        ST_HUNT1: begin
          if (rx_byte == HDR1) begin
            crc_nxt   = crc_upd;
            state_nxt = ST_LENH;
          end else begin
            state_nxt = ST_HUNT0;
          end
        end
        ST_LENH: begin
          crc_nxt   = crc_upd;
          len_nxt   = {rx_byte, 8'd0};
          state_nxt = ST_LENL;
        end
        ST_LENL: begin
          crc_nxt = crc_upd;
          len_nxt = len_full;
          if (len_full < MIN_FRAME_LEN || len_full > MAX_LEN) begin
            state_nxt = ST_HUNT0;
          end else begin
            pos_nxt   = '0;
            rcrc_nxt  = '0;
            tail0_nxt = '0;
            hdr_nxt   = '0;
            state_nxt = ST_BODY;
          end
        end
        ST_BODY: begin
          pos_nxt = pos_r + POS_W'(1);
          if (in_crc) begin
            crc_nxt = crc_upd;
          end
          priority if (in_hdr) begin
            hdr_nxt = {hdr_r[55:0], rx_byte};
          end else if (in_crc) begin
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = rx_byte;
          end else if (in_rcrc) begin
            rcrc_nxt = {rcrc_r[23:0], rx_byte};
          end else if (at_tail0) begin
            tail0_nxt = rx_byte;
          end else begin
            res_valid        = 1'b1;
            res.kind         = KIND_END;
            res.status       = status;
            res.version      = hdr_r[63:56];
            res.frame_type   = hdr_r[55:40];
            res.sequence_res = hdr_r[39:24];
            res.channel      = hdr_r[23:16];
            res.command      = hdr_r[15:0];
            res.arg_length   = arg_len16[ARGLEN_W-1:0];
            state_nxt        = ST_HUNT0;
          end
        end
        default: begin
          state_nxt = ST_HUNT0;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT0;
      len_r   <= '0;
      pos_r   <= '0;
      crc_r   <= CRC_ALL_ONES;
      rcrc_r  <= '0;
      tail0_r <= '0;
      hdr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      rcrc_r  <= rcrc_nxt;
      tail0_r <= tail0_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

`ifndef SYNTH
  // Results only come out of the frame body.
  a_res_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> state_r == ST_BODY)
    else $error("result outside frame body");

  // A frame-end beat always returns the parser to the hunt.
  a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_END) |=> state_r == ST_HUNT0)
    else $error("no return to hunt after frame end");

  // The body position never runs past the last tail byte.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BODY |-> pos_r <= len_r - 16'd5)
    else $error("body position past frame end");
`endif

endmodule

// File: rtl/core/crcfr_outq.sv
// Output register with a skid stage for result beats.
module crcfr_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  crcfr_pkg::result_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output crcfr_pkg::result_t out_data
);
  import crcfr_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    skd_valid_r, skd_valid_nxt;
  result_t out_r, out_nxt;
  result_t skd_r, skd_nxt;
  logic    out_take;

  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign full      = skd_valid_r;

  // Refill the output register from the skid stage first, then from the parser.
  always_comb begin
    out_valid_nxt = out_valid_r;
    skd_valid_nxt = skd_valid_r;
    out_nxt       = out_r;
    skd_nxt       = skd_r;
    if (skd_valid_r) begin
      if (out_take) begin
        out_nxt       = skd_r;
        skd_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_nxt = push_valid;
      out_nxt       = push_data;
    end else if (push_valid) begin
      skd_valid_nxt = 1'b1;
      skd_nxt       = push_data;
    end
  end

  // Valid flags take reset; data registers do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skd_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skd_valid_r <= skd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    skd_r <= skd_nxt;
  end

`ifndef SYNTH
  // The skid stage is only ever occupied behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skd_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output is empty");

  // No beat may arrive while the skid stage is occupied.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !skd_valid_r)
    else $error("beat pushed into full queue");
`endif

endmodule

// File: tb/crc32_frame_receiver_test.sv
// Self-checking testbench for the CRC-32 frame receiver: directed frames, random traffic.
`timescale 1ns / 1ps

module crc32_frame_receiver_test;
  import crcfr_pkg::*;

  // Clock, reset and ports of the block.
  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_payload_byte;
  logic [1:0]  out_frame_status;
  logic [7:0]  out_version;
  logic [15:0] out_frame_type;
  logic [15:0] out_sequence_res;
  logic [7:0]  out_channel;
  logic [15:0] out_command;
  logic [10:0] out_arg_length;

  // Pacing of both channels and the long output hold-off.
  int unsigned idle_pct  = 25;
  int unsigned stall_pct = 70;
  int unsigned hold_left = 0;

  // Predicted result beats in arrival order, and bookkeeping.
  result_t     expected_beats[$];
  logic [7:0]  arg_bytes[$];
  int unsigned bytes_sent  = 0;
  int unsigned error_count = 0;

  // Deframer state as the testbench tracks it.
  sync_state_t hunt_state   = ST_HUNT0;
  logic [15:0] frame_len    = '0;
  logic [15:0] body_pos     = '0;
  logic [31:0] crc_acc      = CRC_ALL_ONES;
  logic [31:0] rx_crc       = '0;
  logic [7:0]  tail_hold    = '0;
  logic [63:0] hdr_fields   = '0;

  crc32_frame_receiver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_status (out_frame_status),
    .out_version      (out_version),
    .out_frame_type   (out_frame_type),
    .out_sequence_res (out_sequence_res),
    .out_channel      (out_channel),
    .out_command      (out_command),
    .out_arg_length   (out_arg_length)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Reflected CRC-32, one input bit at a time, LSB first.
  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY_REFL;
    end
    return c;
  endfunction

  // Advances the tracked deframer by one accepted byte and queues any result it causes.
  task automatic deframe_byte(input logic [7:0] b);
    result_t     beat;
    logic [15:0] p;
    logic [15:0] arg_len16;
    beat = '0;
    case (hunt_state)
      ST_HUNT0: begin
        if (b == HDR0) begin
          crc_acc = crc32_update(CRC_ALL_ONES, b);
          hunt_state = ST_HUNT1;
        end
      end
      ST_HUNT1: begin
        if (b == HDR1) begin
          crc_acc = crc32_update(crc_acc, b);
          hunt_state = ST_LENH;
        end else begin
          hunt_state = ST_HUNT0;
        end
      end
      ST_LENH: begin
        crc_acc = crc32_update(crc_acc, b);
        frame_len = {b, 8'h00};
        hunt_state = ST_LENL;
      end
      ST_LENL: begin
        crc_acc = crc32_update(crc_acc, b);
        frame_len = {frame_len[15:8], b};
        if (frame_len < MIN_FRAME_LEN || frame_len > MAX_FRAME_LEN) begin
          hunt_state = ST_HUNT0;
        end else begin
          body_pos = '0;
          rx_crc = '0;
          tail_hold = '0;
          hdr_fields = '0;
          hunt_state = ST_BODY;
        end
      end
      ST_BODY: begin
        p = body_pos;
        body_pos = p + 16'd1;
        if (p < frame_len - CRC_END_OFS) crc_acc = crc32_update(crc_acc, b);
        if (p < HDR_BYTES) begin
          hdr_fields = {hdr_fields[55:0], b};
        end else if (p < frame_len - CRC_END_OFS) begin
          beat.kind = KIND_PAYLOAD;
          beat.payload_byte = b;
          expected_beats.push_back(beat);
        end else if (p < frame_len - RCRC_END_OFS) begin
          rx_crc = {rx_crc[23:0], b};
        end else if (p == frame_len - RCRC_END_OFS) begin
          tail_hold = b;
        end else begin
          // Last tail byte: a bad tail outranks a bad CRC.
          if (tail_hold != TAIL0 || b != TAIL1) begin
            beat.status = STAT_TAIL_ERR;
          end else if ((crc_acc ^ CRC_ALL_ONES) != rx_crc) begin
            beat.status = STAT_CRC_ERR;
          end else begin
            beat.status = STAT_GOOD;
          end
          arg_len16 = frame_len - MIN_FRAME_LEN;
          beat.kind = KIND_END;
          beat.version = hdr_fields[63:56];
          beat.frame_type = hdr_fields[55:40];
          beat.sequence_res = hdr_fields[39:24];
          beat.channel = hdr_fields[23:16];
          beat.command = hdr_fields[15:0];
          beat.arg_length = arg_len16[ARGLEN_W-1:0];
          expected_beats.push_back(beat);
          hunt_state = ST_HUNT0;
        end
      end
      default: hunt_state = ST_HUNT0;
    endcase
  endtask

  // Output stall: a counted hold-off when one is pending, random otherwise.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      error_count++;
    end
  endfunction

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("result beat arrived with no prediction pending");
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("result_kind", want.kind, out_result_kind);
        check_field("payload_byte", want.payload_byte, out_payload_byte);
        check_field("frame_status", want.status, out_frame_status);
        check_field("version", want.version, out_version);
        check_field("frame_type", want.frame_type, out_frame_type);
        check_field("sequence_res", want.sequence_res, out_sequence_res);
        check_field("channel", want.channel, out_channel);
        check_field("command", want.command, out_command);
        check_field("arg_length", want.arg_length, out_arg_length);
      end
    end
  end

  // Offers one byte with random idle cycles ahead of it; returns at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Changes the pacing of both sides and optionally starts a long output hold-off.
  task automatic set_pacing(input int unsigned idle, input int unsigned stall,
                            input int unsigned hold);
    in_valid <= 1'b0;
    @(posedge clk);
    idle_pct = idle;
    stall_pct = stall;
    hold_left = hold;
    @(negedge clk);
  endtask

  // Builds a frame around the bytes in arg_bytes and sends it. A nonzero crc_flip
  // corrupts the transmitted CRC.
  task automatic send_frame(input logic [7:0] version, input logic [15:0] ftype,
                            input logic [15:0] seq_num, input logic [7:0] chan,
                            input logic [15:0] cmd, input logic [31:0] crc_flip,
                            input logic [7:0] tail0, input logic [7:0] tail1);
    logic [15:0] total_len;
    logic [31:0] crc;
    logic [7:0]  fb[$];
    total_len = MIN_FRAME_LEN + 16'(arg_bytes.size());
    fb.push_back(HDR0);
    fb.push_back(HDR1);
    fb.push_back(total_len[15:8]);
    fb.push_back(total_len[7:0]);
    fb.push_back(version);
    fb.push_back(ftype[15:8]);
    fb.push_back(ftype[7:0]);
    fb.push_back(seq_num[15:8]);
    fb.push_back(seq_num[7:0]);
    fb.push_back(chan);
    fb.push_back(cmd[15:8]);
    fb.push_back(cmd[7:0]);
    foreach (arg_bytes[i]) fb.push_back(arg_bytes[i]);
    crc = CRC_ALL_ONES;
    foreach (fb[i]) crc = crc32_update(crc, fb[i]);
    crc = crc ^ CRC_ALL_ONES ^ crc_flip;
    fb.push_back(crc[31:24]);
    fb.push_back(crc[23:16]);
    fb.push_back(crc[15:8]);
    fb.push_back(crc[7:0]);
    fb.push_back(tail0);
    fb.push_back(tail1);
    foreach (fb[i]) send_byte(fb[i]);
    arg_bytes.delete();
  endtask

  task automatic fill_random_args(input int unsigned count);
    arg_bytes.delete();
    repeat (count) arg_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Shortest frame, with all header fields at zero and then at all ones.
  task automatic test_min_frame_fields;
    send_frame(8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 32'h0, TAIL0, TAIL1);
    send_frame(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 32'h0, TAIL0, TAIL1);
  endtask

  // Argument bytes at the extremes and bytes that look like header or tail.
  task automatic test_payload_extremes;
    arg_bytes = {8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, HDR0, HDR1, TAIL0, TAIL1};
    send_frame(8'h5A, 16'h8001, 16'h7FFE, 8'hA5, 16'h1234, 32'h0, TAIL0, TAIL1);
  endtask

  task automatic test_tail_mismatch;
    fill_random_args(3);
    send_frame(8'h01, 16'h0102, 16'h0304, 8'h05, 16'h0607, 32'h0, 8'hFF, TAIL1);
    fill_random_args(1);
    send_frame(8'h11, 16'h1112, 16'h1314, 8'h15, 16'h1617, 32'h0, TAIL0, 8'hEE);
  endtask

  task automatic test_crc_mismatch;
    fill_random_args(2);
    send_frame(8'h21, 16'h2122, 16'h2324, 8'h25, 16'h2627, 32'h0000_0001, TAIL0, TAIL1);
    send_frame(8'h31, 16'h3132, 16'h3334, 8'h35, 16'h3637, 32'h8000_0000, TAIL0, TAIL1);
  endtask

  // With both the tail and the CRC wrong, the tail verdict wins.
  task automatic test_tail_and_crc_wrong;
    fill_random_args(4);
    send_frame(8'h41, 16'h4142, 16'h4344, 8'h45, 16'h4647, 32'h0001_0000, TAIL1, TAIL0);
  endtask

  // A wrong second header byte is not retried as a first header byte.
  task automatic test_bad_second_header;
    send_byte(HDR0);
    send_byte(HDR0);
    send_byte(HDR1);
    send_byte(8'h00);
    send_byte(8'h12);
    send_byte(HDR0);
    send_byte(8'h00);
    send_frame(8'h51, 16'h5152, 16'h5354, 8'h55, 16'h5657, 32'h0, TAIL0, TAIL1);
  endtask

  // Lengths just outside the legal range and at the field extremes, then recovery.
  task automatic test_length_out_of_range;
    logic [15:0] bad_lens[4];
    bad_lens = '{16'd17, 16'd2049, 16'h0000, 16'hFFFF};
    foreach (bad_lens[i]) begin
      send_byte(HDR0);
      send_byte(HDR1);
      send_byte(bad_lens[i][15:8]);
      send_byte(bad_lens[i][7:0]);
    end
    fill_random_args(1);
    send_frame(8'h61, 16'h6162, 16'h6364, 8'h65, 16'h6667, 32'h0, TAIL0, TAIL1);
  endtask

  // A long frame whose length runs well past one byte of the length field.
  task automatic test_long_frame;
    fill_random_args(300);
    send_frame(8'h71, 16'h7172, 16'h7374, 8'h75, 16'h7677, 32'h0, TAIL0, TAIL1);
  endtask

  // Output held off for a long stretch while a frame streams in back to back.
  task automatic test_input_backpressure;
    set_pacing(0, 0, 60);
    fill_random_args(40);
    send_frame(8'h81, 16'h8182, 16'h8384, 8'h85, 16'h8687, 32'h0, TAIL0, TAIL1);
  endtask

  // Mostly well-formed frames with random content, mixed with damaged frames and noise.
  task automatic run_random_traffic(input int unsigned byte_budget);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    logic [15:0] len;
    logic [7:0]  t0;
    logic [7:0]  t1;
    start = bytes_sent;
    while (bytes_sent - start < byte_budget) begin
      pick = $urandom_range(99);
      n = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(24);
      t0 = TAIL0;
      t1 = TAIL1;
      if (pick < 60) begin
        fill_random_args(n);
        send_frame(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                   16'($urandom), 32'h0, t0, t1);
      end else if (pick < 70) begin
        fill_random_args(n);
        send_frame(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                   16'($urandom), 32'h1 << $urandom_range(31), t0, t1);
      end else if (pick < 78) begin
        // Break one or both tail bytes, sometimes the CRC as well.
        if ($urandom_range(1)) t0 = TAIL0 ^ 8'(1 + $urandom_range(254));
        else t1 = TAIL1 ^ 8'(1 + $urandom_range(254));
        if ($urandom_range(2) == 0) t1 = TAIL1 ^ 8'(1 + $urandom_range(254));
        fill_random_args(n);
        send_frame(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                   16'($urandom), $urandom_range(1) ? 32'h0 : 32'h0000_0100, t0, t1);
      end else if (pick < 85) begin
        repeat (1 + $urandom_range(7)) send_byte(8'($urandom_range(255)));
      end else if (pick < 90) begin
        len = $urandom_range(1) ? 16'($urandom_range(17)) : 16'($urandom_range(65535, 2049));
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end else if (pick < 95) begin
        send_byte(HDR0);
        send_byte(HDR1 ^ 8'(1 + $urandom_range(254)));
      end else begin
        // Legal length followed by a body of random bytes.
        len = MIN_FRAME_LEN + 16'($urandom_range(30));
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        repeat (len - 16'd4) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_min_frame_fields();
    test_payload_extremes();
    test_tail_mismatch();
    test_crc_mismatch();
    test_tail_and_crc_wrong();
    test_bad_second_header();
    test_length_out_of_range();
    test_long_frame();
    run_random_traffic(230);

    set_pacing(70, 25, 0);
    run_random_traffic(230);

    test_input_backpressure();
    run_random_traffic(230);

    // Drain outstanding results, then allow for the output latency.
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
